// ----- design/tbs_pkg.sv -----
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared constants, register codes and controller/datapath types of the
// texture sampler.
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

   localparam int SIZE_W  = 9;
   localparam int CH_W    = 16;
   localparam int TEX_W   = 3 * CH_W;
   localparam int GAIN_W  = 16;
   localparam int COORD_W = 32;
   localparam int POS_W   = 44;
   localparam int FRAC_W  = 16;
   localparam int INT_W   = POS_W - FRAC_W;
   localparam int CNT_W   = $clog2(INT_W);

   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_BORDER = 3'd2;
   localparam logic [2:0] REG_FILTER = 3'd3;
   localparam logic [2:0] REG_GAIN   = 3'd4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic BORDER_CLAMP  = 1'b0;
   localparam logic FILTER_NEAR   = 1'b0;

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic              border;
      logic              filter;
      logic [GAIN_W-1:0] gain;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic       mult;
      logic       prep;
      logic       mod_load;
      logic       mod_step;
      logic       fix;
      logic       axis_y;
      logic [1:0] rd_sel;
      logic       cap_en;
      logic [1:0] cap_sel;
      logic       near;
      logic       row0;
      logic       row1;
      logic       col;
      logic       expose;
   } cmd_type;

endpackage

// ----- design/texture_bilinear_sampler.sv -----
// ----------------------------------------------------------------------------
// texture_bilinear_sampler
// Nearest or bilinear RGB texture sampler with clamp/repeat borders and gain.
// ----------------------------------------------------------------------------
// Usage:
//   Drive start with an item on the req_ ports; the transfer happens on the
//   clock edge where start is high and busy is low.
//   A load item (req_op = 0) writes one texel in that cycle and leaves busy
//   low, so loads can be issued every cycle.
//   A sample item (req_op = 1) raises busy until its result is ready; the
//   result shows on rsp_out_* with rsp_valid high for exactly one cycle, the
//   first cycle with busy low again. No item is taken while busy is high.
//   The sample time is set by the bit-serial remainder unit, which runs one
//   step per cycle over the 28-bit texel index for each axis, plus four reads
//   (one for nearest) of the single-ported texel memory.
//   The receiver cannot stall: each result is a one-cycle strobe.
//   Reset returns the sequencer to idle and the registers to their defaults;
//   the texel memory is not cleared and reads as garbage until written.
//   Configuration is written over psel/penable/pwrite at byte address 4*i;
//   the user must write only while the block is idle; the block does not check.
// ----------------------------------------------------------------------------
module texture_bilinear_sampler
   import tbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_op,
   input  logic [7:0]                req_texel_col,
   input  logic [7:0]                req_texel_row,
   input  logic [CH_W-1:0]           req_load_red,
   input  logic [CH_W-1:0]           req_load_green,
   input  logic [CH_W-1:0]           req_load_blue,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   output logic                      rsp_valid,
   output logic [CH_W-1:0]           rsp_out_red,
   output logic [CH_W-1:0]           rsp_out_green,
   output logic [CH_W-1:0]           rsp_out_blue,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [PDATA_W-1:0]        pwdata,
   output logic [PDATA_W-1:0]        prdata,
   output logic                      pready
);

   cfg_type cfg;
   cmd_type cmd;

   // register file; hold values between writes
   tbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer; advance one step per cycle
   tbs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_op),
      .filter (cfg.filter),
      .busy   (busy),
      .cmd    (cmd)
   );

   // memory, arithmetic and result registers
   tbs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .cfg            (cfg),
      .req_op         (req_op),
      .req_texel_col  (req_texel_col),
      .req_texel_row  (req_texel_row),
      .req_load_red   (req_load_red),
      .req_load_green (req_load_green),
      .req_load_blue  (req_load_blue),
      .req_u_coord    (req_u_coord),
      .req_v_coord    (req_v_coord),
      .rsp_valid      (rsp_valid),
      .rsp_out_red    (rsp_out_red),
      .rsp_out_green  (rsp_out_green),
      .rsp_out_blue   (rsp_out_blue)
   );

endmodule

// ----- design/tbs_csr.sv -----
// ----------------------------------------------------------------------------
// tbs_csr
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tbs_csr
   import tbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type    cfg_ff;
   logic [2:0] index;

   assign index  = paddr[4:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= SIZE_W'(256);
         cfg_ff.height <= SIZE_W'(256);
         cfg_ff.border <= 1'b1;
         cfg_ff.filter <= 1'b1;
         cfg_ff.gain   <= GAIN_W'(256);
      end else if (psel && penable && pwrite) begin
         unique case (index)
            REG_WIDTH:  cfg_ff.width  <= pwdata[SIZE_W-1:0];
            REG_HEIGHT: cfg_ff.height <= pwdata[SIZE_W-1:0];
            REG_BORDER: cfg_ff.border <= pwdata[0];
            REG_FILTER: cfg_ff.filter <= pwdata[0];
            REG_GAIN:   cfg_ff.gain   <= pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_WIDTH:  prdata = PDATA_W'(cfg_ff.width);
         REG_HEIGHT: prdata = PDATA_W'(cfg_ff.height);
         REG_BORDER: prdata = PDATA_W'(cfg_ff.border);
         REG_FILTER: prdata = PDATA_W'(cfg_ff.filter);
         REG_GAIN:   prdata = PDATA_W'(cfg_ff.gain);
         default:    prdata = '0;
      endcase
   end

endmodule

// ----- design/tbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbs_ctrl
// Sequencer: steps the datapath through mapping, remainder, fetch, blend (bilinear only) and exposure.
// ----------------------------------------------------------------------------
module tbs_ctrl
   import tbs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    op,
   input  logic    filter,
   output logic    busy,
   output cmd_type cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MULT = 5'd1;
   localparam logic [4:0] S_PREP = 5'd2;
   localparam logic [4:0] S_LDX  = 5'd3;
   localparam logic [4:0] S_MODX = 5'd4;
   localparam logic [4:0] S_FIXX = 5'd5;
   localparam logic [4:0] S_LDY  = 5'd6;
   localparam logic [4:0] S_MODY = 5'd7;
   localparam logic [4:0] S_FIXY = 5'd8;
   localparam logic [4:0] S_RD0  = 5'd9;
   localparam logic [4:0] S_RD1  = 5'd10;
   localparam logic [4:0] S_RD2  = 5'd11;
   localparam logic [4:0] S_RD3  = 5'd12;
   localparam logic [4:0] S_RD4  = 5'd13;
   localparam logic [4:0] S_NEAR = 5'd14;
   localparam logic [4:0] S_ROW0 = 5'd15;
   localparam logic [4:0] S_ROW1 = 5'd16;
   localparam logic [4:0] S_COL  = 5'd17;
   localparam logic [4:0] S_EXP  = 5'd18;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last_step;

   assign last_step = (cnt_ff == CNT_W'(INT_W - 1));
   assign busy      = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: if (start && op == OP_SAMPLE) state_in = S_MULT;
         S_MULT: state_in = S_PREP;
         S_PREP: state_in = S_LDX;
         S_LDX: begin
            cnt_in   = '0;
            state_in = S_MODX;
         end
         S_MODX: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_step) state_in = S_FIXX;
         end
         S_FIXX: state_in = S_LDY;
         S_LDY: begin
            cnt_in   = '0;
            state_in = S_MODY;
         end
         S_MODY: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_step) state_in = S_FIXY;
         end
         S_FIXY: state_in = S_RD0;
         S_RD0:  state_in = (filter == FILTER_NEAR) ? S_NEAR : S_RD1;
         S_RD1:  state_in = S_RD2;
         S_RD2:  state_in = S_RD3;
         S_RD3:  state_in = S_RD4;
         S_RD4:  state_in = S_ROW0;
         S_NEAR: state_in = S_EXP;
         S_ROW0: state_in = S_ROW1;
         S_ROW1: state_in = S_COL;
         S_COL:  state_in = S_EXP;
         S_EXP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.accept   = (state_ff == S_IDLE) && start;
      cmd.mult     = (state_ff == S_MULT);
      cmd.prep     = (state_ff == S_PREP);
      cmd.mod_load = (state_ff == S_LDX) || (state_ff == S_LDY);
      cmd.mod_step = (state_ff == S_MODX) || (state_ff == S_MODY);
      cmd.fix      = (state_ff == S_FIXX) || (state_ff == S_FIXY);
      cmd.axis_y   = (state_ff == S_LDY) || (state_ff == S_FIXY);
      cmd.near     = (state_ff == S_NEAR);
      cmd.row0     = (state_ff == S_ROW0);
      cmd.row1     = (state_ff == S_ROW1);
      cmd.col      = (state_ff == S_COL);
      cmd.expose   = (state_ff == S_EXP);
      unique case (state_ff)
         S_RD1: cmd.rd_sel = 2'd1;
         S_RD2: cmd.rd_sel = 2'd2;
         S_RD3: cmd.rd_sel = 2'd3;
         default: cmd.rd_sel = 2'd0;
      endcase
      cmd.cap_en = (state_ff == S_RD1) || (state_ff == S_RD2) ||
                   (state_ff == S_RD3) || (state_ff == S_RD4);
      unique case (state_ff)
         S_RD2: cmd.cap_sel = 2'd1;
         S_RD3: cmd.cap_sel = 2'd2;
         S_RD4: cmd.cap_sel = 2'd3;
         default: cmd.cap_sel = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- design/tbs_datapath.sv -----
// ----------------------------------------------------------------------------
// tbs_datapath
// Texel memory, coordinate mapping, serial remainder, blend and exposure.
// ----------------------------------------------------------------------------
module tbs_datapath
   import tbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  cfg_type                   cfg,
   input  logic                      req_op,
   input  logic [7:0]                req_texel_col,
   input  logic [7:0]                req_texel_row,
   input  logic [CH_W-1:0]           req_load_red,
   input  logic [CH_W-1:0]           req_load_green,
   input  logic [CH_W-1:0]           req_load_blue,
   input  logic signed [COORD_W-1:0] req_u_coord,
   input  logic signed [COORD_W-1:0] req_v_coord,
   output logic                      rsp_valid,
   output logic [CH_W-1:0]           rsp_out_red,
   output logic [CH_W-1:0]           rsp_out_green,
   output logic [CH_W-1:0]           rsp_out_blue
);

   // texel memory, red in the low lane
   logic [TEX_W-1:0]  mem [DEPTH];
   logic [TEX_W-1:0]  rdata_ff;
   logic [ADDR_W-1:0] mem_addr, wr_addr, rd_addr;
   logic              wr_en;

   logic signed [COORD_W-1:0] u_ff, v_ff;
   logic signed [POS_W-1:0]   x_ff, y_ff, x_in, y_in;
   logic [SIZE_W-1:0]         w_eff, h_eff;
   logic signed [INT_W-1:0]   cx_ff, cy_ff, cx_in, cy_in;
   logic [FRAC_W-1:0]         tx_ff, ty_ff;

   logic [SIZE_W-1:0]       rem_ff, div_ff;
   logic [INT_W-1:0]        dvd_ff;
   logic                    neg_ff;
   logic [SIZE_W:0]         trial;
   logic signed [INT_W-1:0] mod_src, fix_c;

   logic [SIZE_W-1:0] modv, modp1;
   logic [COL_W-1:0]  x0_ff, x1_ff;
   logic [ROW_W-1:0]  y0_ff, y1_ff;
   logic [SIZE_W-1:0] i0, i1;

   logic [TEX_W-1:0]  tex_ff [4];
   logic [31:0]       r0_ff [3], r1_ff [3], val_ff [3];
   logic [31:0]       row_res [3], col_res [3];
   logic [CH_W-1:0]   exp_res [3];
   logic [CH_W-1:0]   out_ff [3];
   logic              valid_ff;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                  input int lim);
      logic [SIZE_W-1:0] r;
      r = s;
      if (s == '0) r = SIZE_W'(1);
      if (int'(s) > lim) r = SIZE_W'(lim);
      return r;
   endfunction

   function automatic logic signed [INT_W-1:0] round_q16(
         input logic signed [POS_W-1:0] p);
      logic [POS_W-1:0] mag;
      logic [INT_W-1:0] q;
      mag = p[POS_W-1] ? POS_W'(-p) : POS_W'(p);
      mag = mag + POS_W'(32768);
      q   = mag[POS_W-1:FRAC_W];
      return p[POS_W-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_idx(input logic signed [INT_W-1:0] c,
                                                    input logic [SIZE_W-1:0] d);
      logic signed [INT_W-1:0] top;
      top = $signed(INT_W'(d)) - INT_W'(1);
      if (c < 0) return '0;
      if (c > top) return top[SIZE_W-1:0];
      return c[SIZE_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] tex_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
   endfunction

   assign w_eff = eff_size(cfg.width, MAX_WIDTH);
   assign h_eff = eff_size(cfg.height, MAX_HEIGHT);

   // memory port: load writes at accept, fetches read in the sequencer
   assign wr_en   = cmd.accept && (req_op == OP_LOAD) &&
                    (int'(req_texel_col) < MAX_WIDTH) && (int'(req_texel_row) < MAX_HEIGHT);
   assign wr_addr = tex_addr(ROW_W'(req_texel_row), COL_W'(req_texel_col));
   always_comb begin
      unique case (cmd.rd_sel)
         2'd0: rd_addr = tex_addr(y0_ff, x0_ff);
         2'd1: rd_addr = tex_addr(y0_ff, x1_ff);
         2'd2: rd_addr = tex_addr(y1_ff, x0_ff);
         2'd3: rd_addr = tex_addr(y1_ff, x1_ff);
         default: rd_addr = '0;
      endcase
   end
   assign mem_addr = wr_en ? wr_addr : rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) mem[mem_addr] <= {req_load_blue, req_load_green, req_load_red};
      rdata_ff <= mem[mem_addr];
   end

   // coordinate mapping
   assign x_in = $signed({{(POS_W-COORD_W){u_ff[COORD_W-1]}}, u_ff}) *
                 $signed({{(POS_W-SIZE_W){1'b0}}, w_eff}) - POS_W'(32768);
   assign y_in = ($signed(POS_W'(65536)) - $signed({{(POS_W-COORD_W){v_ff[COORD_W-1]}}, v_ff})) *
                 $signed({{(POS_W-SIZE_W){1'b0}}, h_eff}) - POS_W'(32768);
   assign cx_in = (cfg.filter == FILTER_NEAR) ? round_q16(x_ff) : x_ff[POS_W-1:FRAC_W];
   assign cy_in = (cfg.filter == FILTER_NEAR) ? round_q16(y_ff) : y_ff[POS_W-1:FRAC_W];

   // bit-serial remainder of |c| by the size
   assign mod_src = cmd.axis_y ? cy_ff : cx_ff;
   assign trial   = {rem_ff, dvd_ff[INT_W-1]};
   assign fix_c   = cmd.axis_y ? cy_ff : cx_ff;
   assign modv    = (neg_ff && rem_ff != '0) ? div_ff - rem_ff : rem_ff;
   assign modp1   = modv + 1'b1;

   always_comb begin
      if (cfg.border == BORDER_CLAMP) begin
         i0 = clamp_idx(fix_c, div_ff);
         i1 = clamp_idx(fix_c + INT_W'(1), div_ff);
      end else begin
         i0 = modv;
         i1 = (modp1 == div_ff) ? '0 : modp1;
      end
   end

   // blend lanes
   always_comb begin
      logic [CH_W-1:0]       a, b;
      logic signed [33:0]    pr;
      logic signed [49:0]    pc;
      logic [47:0]           ep;
      logic [48:0]           er;
      for (int k = 0; k < 3; k++) begin
         a  = cmd.row1 ? tex_ff[2][CH_W*k +: CH_W] : tex_ff[0][CH_W*k +: CH_W];
         b  = cmd.row1 ? tex_ff[3][CH_W*k +: CH_W] : tex_ff[1][CH_W*k +: CH_W];
         pr = $signed({18'b0, a} << 16) +
              $signed({18'b0, tx_ff}) * ($signed({18'b0, b}) - $signed({18'b0, a}));
         row_res[k] = pr[31:0];
         pc = $signed({18'b0, r0_ff[k]} << 16) +
              $signed({34'b0, ty_ff}) * ($signed({18'b0, r1_ff[k]}) - $signed({18'b0, r0_ff[k]}));
         pc = pc + 50'sd32768;
         col_res[k] = pc[47:16];
         ep = 48'(val_ff[k]) * 48'(cfg.gain);
         er = 49'(ep) + 49'(1 << 23);
         exp_res[k] = (er[48:24] > 25'd65535) ? 16'hFFFF : er[39:24];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         u_ff <= req_u_coord;
         v_ff <= req_v_coord;
      end
      if (cmd.mult) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (cmd.prep) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         tx_ff <= x_ff[FRAC_W-1:0];
         ty_ff <= y_ff[FRAC_W-1:0];
      end
      if (cmd.mod_load) begin
         rem_ff <= '0;
         neg_ff <= mod_src[INT_W-1];
         dvd_ff <= mod_src[INT_W-1] ? INT_W'(-mod_src) : INT_W'(mod_src);
         div_ff <= cmd.axis_y ? h_eff : w_eff;
      end else if (cmd.mod_step) begin
         rem_ff <= (trial >= {1'b0, div_ff}) ? SIZE_W'(trial - {1'b0, div_ff})
                                             : trial[SIZE_W-1:0];
         dvd_ff <= dvd_ff << 1;
      end
      if (cmd.fix) begin
         if (cmd.axis_y) begin
            y0_ff <= ROW_W'(i0);
            y1_ff <= ROW_W'(i1);
         end else begin
            x0_ff <= COL_W'(i0);
            x1_ff <= COL_W'(i1);
         end
      end
      if (cmd.cap_en) tex_ff[cmd.cap_sel] <= rdata_ff;
      for (int k = 0; k < 3; k++) begin
         if (cmd.row0) r0_ff[k] <= row_res[k];
         if (cmd.row1) r1_ff[k] <= row_res[k];
         if (cmd.col)  val_ff[k] <= col_res[k];
         if (cmd.near) val_ff[k] <= {rdata_ff[CH_W*k +: CH_W], 16'b0};
         if (cmd.expose) out_ff[k] <= exp_res[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= cmd.expose;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

endmodule

// ----- design/tbs_checker.sv -----
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the sampler's command and result timing.
// ----------------------------------------------------------------------------
module tbs_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_valid
);

   // a sample transfer occupies the block
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op |=> busy)
      else $error("sample transfer did not raise busy");

   // a load transfer completes in its own cycle
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_op |=> !busy)
      else $error("load transfer raised busy");

   // a result shows only once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a result strobe lasts one cycle
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // reset leaves the block idle and quiet
   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind texture_bilinear_sampler tbs_checker u_tbs_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_valid (rsp_valid)
);

// ----- test/tb_texture_bilinear_sampler.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_texture_bilinear_sampler
// Self-checking bench for the texture sampler. Fills a small square of the
// texel memory first and keeps every texture size inside it, so no sample
// can ever touch an unwritten entry. Then runs directed corner samples, and
// random load/sample traffic over several register settings and sender idle
// rates. An in-bench model predicts every result.
// ----------------------------------------------------------------------------
module tb_texture_bilinear_sampler;
   import tbs_pkg::*;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   // side of the filled texel square; texture sizes stay within it
   localparam int FILL_SIZE = 16;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_op = OP_LOAD;
   logic [7:0]                req_texel_col = '0;
   logic [7:0]                req_texel_row = '0;
   logic [CH_W-1:0]           req_load_red = '0;
   logic [CH_W-1:0]           req_load_green = '0;
   logic [CH_W-1:0]           req_load_blue = '0;
   logic signed [COORD_W-1:0] req_u_coord = '0;
   logic signed [COORD_W-1:0] req_v_coord = '0;
   logic                      rsp_valid;
   logic [CH_W-1:0]           rsp_out_red;
   logic [CH_W-1:0]           rsp_out_green;
   logic [CH_W-1:0]           rsp_out_blue;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [PADDR_W-1:0]        paddr = '0;
   logic [PDATA_W-1:0]        pwdata = '0;
   logic [PDATA_W-1:0]        prdata;
   logic                      pready;

   // shadow of the texel memory and the configuration registers
   logic [TEX_W-1:0]  texel_shadow [DEPTH];
   logic [SIZE_W-1:0] shadow_width  = 9'd256;
   logic [SIZE_W-1:0] shadow_height = 9'd256;
   logic              shadow_border = 1'b1;
   logic              shadow_filter = 1'b1;
   logic [GAIN_W-1:0] shadow_gain   = 16'd256;

   rgb_type pending_colors[$];
   int      mismatches = 0;
   int      loads_sent = 0;
   int      samples_sent = 0;
   int      colors_checked = 0;
   int      idle_percent = 0;

   always #10 clock = ~clock;

   texture_bilinear_sampler i_dut (.*);

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   // Map an integer texel index onto the texture per the border mode.
   function automatic longint edge_index(longint c, longint size);
      longint m;
      if (shadow_border == BORDER_CLAMP) begin
         if (c < 0) return 0;
         if (c > size - 1) return size - 1;
         return c;
      end
      m = c % size;
      if (m < 0) m += size;
      return m;
   endfunction

   // Apply gain to a channel scaled by 2^16, round half up, saturate.
   function automatic logic [CH_W-1:0] apply_gain(longint unsigned scaled);
      longint unsigned p;
      p = (scaled * shadow_gain + (64'd1 << 23)) >> 24;
      return (p > 65535) ? 16'hFFFF : p[15:0];
   endfunction

   function automatic logic [CH_W-1:0] channel_of(logic [TEX_W-1:0] t, int ch);
      return t[TEX_W-1-CH_W*ch -: CH_W];
   endfunction

   function automatic rgb_type sample_color(logic signed [31:0] u,
                                            logic signed [31:0] v);
      longint          w, h, x, y, ix, iy, fx, fy, x0, x1, y0, y1;
      longint unsigned tx, ty, r0, r1, acc;
      logic [TEX_W-1:0] t00, t10, t01, t11;
      logic [CH_W-1:0]  chan [3];
      rgb_type          res;
      w = (shadow_width < 1) ? 1 : (shadow_width > MAX_WIDTH) ? MAX_WIDTH : shadow_width;
      h = (shadow_height < 1) ? 1 :
          (shadow_height > MAX_HEIGHT) ? MAX_HEIGHT : shadow_height;
      x = longint'(u) * w - 32768;
      y = (65536 - longint'(v)) * h - 32768;
      if (shadow_filter == FILTER_NEAR) begin
         // round half away from zero
         ix = (x >= 0) ? ((x + 32768) >>> 16) : -((-x + 32768) >>> 16);
         iy = (y >= 0) ? ((y + 32768) >>> 16) : -((-y + 32768) >>> 16);
         t00 = texel_shadow[edge_index(iy, h) * MAX_WIDTH + edge_index(ix, w)];
         for (int ch = 0; ch < 3; ch++)
            chan[ch] = apply_gain(longint'(channel_of(t00, ch)) << 16);
      end else begin
         fx = x >>> 16;
         fy = y >>> 16;
         tx = x & 64'hFFFF;
         ty = y & 64'hFFFF;
         x0 = edge_index(fx, w);
         x1 = edge_index(fx + 1, w);
         y0 = edge_index(fy, h);
         y1 = edge_index(fy + 1, h);
         t00 = texel_shadow[y0 * MAX_WIDTH + x0];
         t10 = texel_shadow[y0 * MAX_WIDTH + x1];
         t01 = texel_shadow[y1 * MAX_WIDTH + x0];
         t11 = texel_shadow[y1 * MAX_WIDTH + x1];
         for (int ch = 0; ch < 3; ch++) begin
            r0  = tx * channel_of(t10, ch) + (65536 - tx) * channel_of(t00, ch);
            r1  = tx * channel_of(t11, ch) + (65536 - tx) * channel_of(t01, ch);
            acc = ty * r1 + (65536 - ty) * r0;
            chan[ch] = apply_gain((acc + (64'd1 << 15)) >> 16);
         end
      end
      res.red   = chan[0];
      res.green = chan[1];
      res.blue  = chan[2];
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------
   // Send one item; start stays high after the transfer so the next call
   // can follow back to back without toggling it in one time step.
   // Idle the sender cycle by cycle at the current idle rate first.
   task automatic send_item(logic op, logic [7:0] col, logic [7:0] row,
                            logic [47:0] rgb, logic signed [31:0] u,
                            logic signed [31:0] v);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_op         <= op;
      req_texel_col  <= col;
      req_texel_row  <= row;
      req_load_red   <= rgb[47:32];
      req_load_green <= rgb[31:16];
      req_load_blue  <= rgb[15:0];
      req_u_coord    <= u;
      req_v_coord    <= v;
      do @(posedge clock); while (busy);
      // transfer happened at this edge
      if (op == OP_LOAD) begin
         texel_shadow[{row, col}] = rgb;
         loads_sent++;
      end else begin
         pending_colors.push_back(sample_color(u, v));
         samples_sent++;
      end
   endtask

   task automatic send_load(logic [7:0] col, logic [7:0] row, logic [47:0] rgb);
      send_item(OP_LOAD, col, row, rgb, $urandom, $urandom);
   endtask

   task automatic send_sample(logic signed [31:0] u, logic signed [31:0] v);
      send_item(OP_SAMPLE, 8'($urandom), 8'($urandom), 48'({$urandom, $urandom}), u, v);
   endtask

   // Hold off until every result is in and the block has settled.
   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_colors.size() != 0 || busy);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_WIDTH:  shadow_width  = value[SIZE_W-1:0];
         REG_HEIGHT: shadow_height = value[SIZE_W-1:0];
         REG_BORDER: shadow_border = value[0];
         REG_FILTER: shadow_filter = value[0];
         REG_GAIN:   shadow_gain   = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_mode(int w, int h, logic brd, logic flt, int gain);
      drain();
      write_reg(REG_WIDTH, 32'(w));
      write_reg(REG_HEIGHT, 32'(h));
      write_reg(REG_BORDER, 32'(brd));
      write_reg(REG_FILTER, 32'(flt));
      write_reg(REG_GAIN, 32'(gain));
   endtask

   // Mostly coordinates near the texture, sometimes anything at all.
   function automatic logic signed [31:0] random_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return $urandom_range(65536);
         default: return int'($urandom_range(6 * 65536)) - 3 * 65536;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Write every texel of the square so that no sample reads an unwritten entry.
   task automatic test_fill_memory;
      idle_percent = 0;
      for (int i = 0; i < FILL_SIZE * FILL_SIZE; i++)
         send_load(8'(i % FILL_SIZE), 8'(i / FILL_SIZE), 48'({$urandom, $urandom}));
   endtask

   task automatic test_corners;
      idle_percent = 0;
      set_mode(FILL_SIZE, FILL_SIZE, 1'b1, 1'b1, 256);
      send_load(8'd0, 8'd0, 48'h0);
      send_load(8'(FILL_SIZE - 1), 8'(FILL_SIZE - 1), 48'hFFFF_FFFF_FFFF);
      send_load(8'(FILL_SIZE - 1), 8'd0, 48'hFFFF_0000_FFFF);
      send_load(8'd0, 8'(FILL_SIZE - 1), 48'h0000_FFFF_0000);
      send_sample(32'sd0, 32'sd0);
      send_sample(32'sd65536, 32'sd65536);
      send_sample(32'sd32768, 32'sd32768);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF);
      send_sample(-32'sd1, 32'sd65537);
      // nearest, clamped, full gain: rounding ties and saturation
      set_mode(FILL_SIZE, FILL_SIZE, BORDER_CLAMP, FILTER_NEAR, 65535);
      send_sample(32'sd4096, 32'sd61440);
      send_sample(32'sd0, 32'sd0);
      send_sample(-32'sd65536, 32'sd131072);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      // single texel texture, zero gain
      set_mode(1, 1, 1'b1, 1'b1, 0);
      send_sample(32'sd12345, -32'sd98765);
      set_mode(1, 1, BORDER_CLAMP, FILTER_NEAR, 256);
      send_sample(32'sd12345, -32'sd98765);
   endtask

   // Random traffic under one register setting; the receiver never stalls,
   // so only the sender idle rate varies.
   task automatic test_random_traffic(int count, int pct);
      idle_percent = pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 35)
            send_load(8'($urandom_range(FILL_SIZE - 1)), 8'($urandom_range(FILL_SIZE - 1)),
                      48'({$urandom, $urandom}));
         else
            send_sample(random_coord(), random_coord());
      end
   endtask

   task automatic test_settings_sweep;
      int pcts [4] = '{0, 83, 0, 33};
      for (int k = 0; k < 8; k++) begin
         case (k)
            0: set_mode(FILL_SIZE, FILL_SIZE, 1'b1, 1'b1, 256);
            1: set_mode(1, FILL_SIZE, BORDER_CLAMP, 1'b1, 65535);
            2: set_mode(FILL_SIZE, 0, 1'b1, FILTER_NEAR, 0);
            3: set_mode(3, 5, BORDER_CLAMP, FILTER_NEAR, 300);
            default: set_mode($urandom_range(1, FILL_SIZE), $urandom_range(1, FILL_SIZE),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom_range(65535));
         endcase
         test_random_traffic(48, pcts[k % 4]);
      end
   endtask

   // ------------------------------------------------------------------
   // Result checking: each strobe is one transfer, compare with the oldest
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rgb_type want;
      if (!reset && rsp_valid) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %h %h %h", rsp_out_red, rsp_out_green,
                        rsp_out_blue);
         end else begin
            want = pending_colors.pop_front();
            colors_checked++;
            if (want.red !== rsp_out_red || want.green !== rsp_out_green ||
                want.blue !== rsp_out_blue) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch rgb: expected %h %h %h, got %h %h %h",
                           want.red, want.green, want.blue,
                           rsp_out_red, rsp_out_green, rsp_out_blue);
            end
         end
      end
   end

   initial begin
      #50ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_memory();
      test_corners();
      test_settings_sweep();
      drain();
      $display("covered %0d loads and %0d samples, %0d results checked",
               loads_sent, samples_sent, colors_checked);
      $display("over clamp/repeat, nearest/bilinear, sizes 0..16, gains 0..65535");
      if (mismatches == 0 && pending_colors.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
